// ===== sv/tsi_pkg.sv =====
// shared types and constants of the timestamped snapshot interpolator
package tsi_pkg;

  localparam logic [1:0] KIND_STORE = 2'd0;
  localparam logic [1:0] KIND_QUERY = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  localparam logic [2:0] REG_DELAY = 3'd0;
  localparam logic [2:0] REG_TELE  = 3'd4;

  localparam logic [15:0] DELAY_RESET = 16'd144;
  localparam logic [31:0] TELE_RESET  = 32'd40960000;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECODE, ST_SCAN_RD, ST_SCAN_EV, ST_RD0, ST_RD1, ST_CAP1,
    ST_DIVI, ST_DIV, ST_MULI, ST_MUL, ST_FIN
  } state_t;

  typedef enum logic [1:0] {RES_ZERO, RES_STORE, RES_QUERY} res_t;

  typedef enum logic [1:0] {RD_SCAN, RD_FIRST, RD_SECOND} rd_sel_t;

  typedef struct packed {
    logic [31:0]        stamp;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [15:0] facing;
    logic signed [15:0] speed;
    logic [7:0]         move;
    logic signed [7:0]  item;
  } entry_t;

  typedef struct packed {
    logic    load;
    logic    store;
    logic    clear;
    logic    scan_init;
    logic    scan_ev;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    cap0;
    logic    cap1;
    logic    div_init;
    logic    div_step;
    logic    mul_init;
    logic    mul_step;
    logic    out_load;
    res_t    res;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       peer_ok;
    logic       empty;
    logic       scan_last;
    logic       div_done;
    logic       mul_done;
  } status_t;

endpackage

// ===== sv/timestamped_snapshot_interpolator.sv =====
// top level: register port, controller and datapath of the snapshot interpolator
//  channel   direction  handshake          payload
//  input     in         in_valid/in_stall  kind, peer, src_frame, time_now, in_*
//  result    out        out_valid/out_stall have_data, sample_accepted, snapped, out_*
//  config    in         psel/penable/pwrite interp_delay (0x0), teleport_dist_sq (0x4)
// one word at a time: input stalls from acceptance until the result is presented; store,
// clear and empty query go through decode straight to the result step
// a query adds a scan of the n ring entries (a read and an evaluation each), reads of the
// two bracketing entries, divider setup and 16 quotient bits, multiplier setup and steps
// reset clears the per-peer state and holds off input; snapshot memory is not cleared
// a stalled result holds the block in its last step until it is taken
module timestamped_snapshot_interpolator import tsi_pkg::*; #(
  parameter int PEER_SLOTS = 9,
  parameter int RING_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         kind,
  input  logic [3:0]         peer,
  input  logic [31:0]        src_frame,
  input  logic [31:0]        time_now,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic signed [15:0] in_facing,
  input  logic signed [15:0] in_speed,
  input  logic [7:0]         in_move_state,
  input  logic signed [7:0]  in_item_kind,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               have_data,
  output logic               sample_accepted,
  output logic               snapped,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic signed [15:0] out_facing,
  output logic signed [15:0] out_speed,
  output logic [7:0]         out_move_state,
  output logic signed [7:0]  out_item_kind,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [15:0] interp_delay;
  logic [31:0] teleport_dist_sq;
  cmd_t        cmd;
  status_t     status;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      interp_delay     <= DELAY_RESET;
      teleport_dist_sq <= TELE_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr == REG_DELAY) interp_delay <= pwdata[15:0];
      else if (paddr == REG_TELE) teleport_dist_sq <= pwdata;
    end
  end

  always_comb begin
    unique case (paddr)
      REG_DELAY: prdata = {16'd0, interp_delay};
      REG_TELE:  prdata = teleport_dist_sq;
      default:   prdata = '0;
    endcase
  end

  tsi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  tsi_dp #(
    .PEER_SLOTS (PEER_SLOTS),
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .kind             (kind),
    .peer             (peer),
    .src_frame        (src_frame),
    .time_now         (time_now),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_pos_z         (in_pos_z),
    .in_facing        (in_facing),
    .in_speed         (in_speed),
    .in_move_state    (in_move_state),
    .in_item_kind     (in_item_kind),
    .interp_delay     (interp_delay),
    .teleport_dist_sq (teleport_dist_sq),
    .have_data        (have_data),
    .sample_accepted  (sample_accepted),
    .snapped          (snapped),
    .out_pos_x        (out_pos_x),
    .out_pos_y        (out_pos_y),
    .out_pos_z        (out_pos_z),
    .out_facing       (out_facing),
    .out_speed        (out_speed),
    .out_move_state   (out_move_state),
    .out_item_kind    (out_item_kind)
  );

endmodule

// ===== sv/tsi_ctrl.sv =====
// controller state machine of the snapshot interpolator
module tsi_ctrl import tsi_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  output cmd_t    cmd,
  input  status_t status
);

  state_t state, state_next;
  res_t   res, res_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res       <= RES_ZERO;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      res       <= res_next;
      out_valid <= out_valid_next;
    end
  end

  assign in_stall = rst || (state != ST_IDLE);

  always_comb begin
    state_next     = state;
    res_next       = res;
    out_valid_next = out_valid && out_stall;
    cmd            = '0;
    cmd.rd_sel     = RD_SCAN;
    cmd.res        = res;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        res_next   = RES_ZERO;
        state_next = ST_FIN;
        if (status.peer_ok) begin
          unique case (status.kind)
            KIND_STORE: begin
              cmd.store = 1'b1;
              res_next  = RES_STORE;
            end
            KIND_CLEAR: cmd.clear = 1'b1;
            KIND_QUERY: begin
              if (!status.empty) begin
                cmd.scan_init = 1'b1;
                res_next      = RES_QUERY;
                state_next    = ST_SCAN_RD;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_SCAN;
        state_next = ST_SCAN_EV;
      end
      ST_SCAN_EV: begin
        cmd.scan_ev = 1'b1;
        state_next  = status.scan_last ? ST_RD0 : ST_SCAN_RD;
      end
      ST_RD0: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_FIRST;
        state_next = ST_RD1;
      end
      ST_RD1: begin
        cmd.cap0   = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_SECOND;
        state_next = ST_CAP1;
      end
      ST_CAP1: begin
        cmd.cap1   = 1'b1;
        state_next = ST_DIVI;
      end
      ST_DIVI: begin
        cmd.div_init = 1'b1;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        if (status.div_done) state_next = ST_MULI;
        else cmd.div_step = 1'b1;
      end
      ST_MULI: begin
        cmd.mul_init = 1'b1;
        state_next   = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
        if (status.mul_done) state_next = ST_FIN;
      end
      ST_FIN: begin
        if (!(out_valid && out_stall)) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  a_load_decode: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && in_valid) |=> state == ST_DECODE)
    else $error("accepted word did not reach decode");
  a_fin_out: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && !(out_valid && out_stall)) |=> (out_valid && state == ST_IDLE))
    else $error("result not presented");
  a_div_mul: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && status.div_done) |=> state == ST_MULI)
    else $error("divider finish lost");
  a_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result dropped");

endmodule

// ===== sv/tsi_dp.sv =====
// datapath: snapshot memory, peer state, scan, divider and shared multiplier
module tsi_dp import tsi_pkg::*; #(
  parameter int PEER_SLOTS = 9,
  parameter int RING_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output status_t            status,
  input  logic [1:0]         kind,
  input  logic [3:0]         peer,
  input  logic [31:0]        src_frame,
  input  logic [31:0]        time_now,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic signed [15:0] in_facing,
  input  logic signed [15:0] in_speed,
  input  logic [7:0]         in_move_state,
  input  logic signed [7:0]  in_item_kind,
  input  logic [15:0]        interp_delay,
  input  logic [31:0]        teleport_dist_sq,
  output logic               have_data,
  output logic               sample_accepted,
  output logic               snapped,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic signed [15:0] out_facing,
  output logic signed [15:0] out_speed,
  output logic [7:0]         out_move_state,
  output logic signed [7:0]  out_item_kind
);

  localparam int PW = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
  localparam int RW = $clog2(RING_DEPTH);
  localparam int CW = $clog2(RING_DEPTH + 1);
  localparam int MD = PEER_SLOTS << RW;

  // latched word
  logic [1:0]  kind_q;
  logic [3:0]  peer_q;
  logic [31:0] frame_q, now_q;
  entry_t      in_q;

  // peer state
  logic [CW-1:0] vcnt   [PEER_SLOTS];
  logic [RW-1:0] head   [PEER_SLOTS];
  logic [31:0]   nframe [PEER_SLOTS];
  logic          seen   [PEER_SLOTS];

  entry_t mem [MD];
  entry_t rdata;
  logic [PW+RW-1:0] raddr;

  logic [PW-1:0] pidx;
  logic          peer_ok;
  logic [RW-1:0] oldest, cur_idx, scan_idx, i0, i1;
  logic [CW-1:0] ncnt, si;
  logic          i0f, i1f, accepted;
  entry_t        e0, e1;

  logic signed [33:0] tgt, diff, span;
  logic [32:0]        rem;
  logic [33:0]        rem2;
  logic [16:0]        tq;
  logic [4:0]         dcnt;

  logic [3:0]         mcnt;
  logic signed [33:0] ma;
  logic signed [17:0] mb;
  logic signed [51:0] prod;
  logic [34:0]        sum;
  logic               big;
  logic signed [31:0] lp_x, lp_y, lp_z;
  logic signed [15:0] lp_s, lp_f;

  logic signed [32:0] dx, dy, dz;
  logic signed [16:0] ds;
  logic signed [15:0] df;
  logic [2:0]         bigc;
  logic signed [32:0] dsel;
  logic [3:0]         kd;
  logic signed [35:0] rnd;
  logic signed [51:0] ftr;
  logic [RW+1:0]      osum, isum;
  logic               snap_now;

  assign pidx    = PW'(peer_q);
  assign peer_ok = 7'(peer_q) < 7'(PEER_SLOTS);
  assign ncnt    = vcnt[pidx];

  always_comb begin
    osum = (RW+2)'(head[pidx]) + (RW+2)'(RING_DEPTH) - (RW+2)'(ncnt);
    if (osum >= (RW+2)'(RING_DEPTH)) osum = osum - (RW+2)'(RING_DEPTH);
    isum = (RW+2)'(oldest) + (RW+2)'(si);
    if (isum >= (RW+2)'(RING_DEPTH)) isum = isum - (RW+2)'(RING_DEPTH);
  end
  assign scan_idx = isum[RW-1:0];

  assign status.kind      = kind_q;
  assign status.peer_ok   = peer_ok;
  assign status.empty     = (ncnt == '0);
  assign status.scan_last = ((si + CW'(1)) == ncnt);
  assign status.div_done  = (dcnt == '0);
  assign status.mul_done  = (mcnt == 4'd8);

  always_comb begin
    unique case (cmd.rd_sel)
      RD_SCAN:   raddr = {pidx, scan_idx};
      RD_FIRST:  raddr = {pidx, i0f ? i0 : i1};
      RD_SECOND: raddr = {pidx, (i0f && i1f) ? i1 : (i0f ? i0 : i1)};
      default:   raddr = {pidx, scan_idx};
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.store && !(seen[pidx] && frame_q <= nframe[pidx]))
      mem[{pidx, head[pidx]}] <= in_q;
    if (cmd.rd_en) rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < PEER_SLOTS; k++) begin
        vcnt[k]   <= '0;
        head[k]   <= '0;
        nframe[k] <= '0;
        seen[k]   <= 1'b0;
      end
    end else if (cmd.store) begin
      if (!(seen[pidx] && frame_q <= nframe[pidx])) begin
        nframe[pidx] <= frame_q;
        seen[pidx]   <= 1'b1;
        head[pidx]   <= (head[pidx] == RW'(RING_DEPTH - 1)) ? '0 : head[pidx] + RW'(1);
        if (vcnt[pidx] < CW'(RING_DEPTH)) vcnt[pidx] <= vcnt[pidx] + CW'(1);
      end
    end else if (cmd.clear) begin
      vcnt[pidx]   <= '0;
      head[pidx]   <= '0;
      nframe[pidx] <= '0;
      seen[pidx]   <= 1'b0;
    end
  end

  assign tgt = $signed({2'b00, now_q}) - $signed({18'd0, interp_delay});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q    <= kind;
      peer_q    <= peer;
      frame_q   <= src_frame;
      now_q     <= time_now;
      in_q      <= '{time_now, in_pos_x, in_pos_y, in_pos_z, in_facing, in_speed,
                     in_move_state, in_item_kind};
    end
    if (cmd.store) accepted <= !(seen[pidx] && frame_q <= nframe[pidx]);
    if (cmd.scan_init) begin
      oldest <= osum[RW-1:0];
      si     <= '0;
      i0f    <= 1'b0;
      i1f    <= 1'b0;
    end
    if (cmd.rd_en && cmd.rd_sel == RD_SCAN) cur_idx <= scan_idx;
    if (cmd.scan_ev) begin
      if ($signed({2'b00, rdata.stamp}) <= tgt) begin
        i0  <= cur_idx;
        i0f <= 1'b1;
      end else if (!i1f) begin
        i1  <= cur_idx;
        i1f <= 1'b1;
      end
      si <= si + CW'(1);
    end
    if (cmd.cap0) e0 <= rdata;
    if (cmd.cap1) e1 <= rdata;
  end

  // fraction of the span, one quotient bit a cycle
  assign diff = tgt - $signed({2'b00, e0.stamp});
  assign span = $signed({2'b00, e1.stamp}) - $signed({2'b00, e0.stamp});
  assign rem2 = {rem, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      dcnt <= '0;
    end else if (cmd.div_init) begin
      if (!(i0f && i1f)) begin
        tq   <= '0;
        dcnt <= '0;
      end else if (span[33] || span == '0 || diff >= span) begin
        tq   <= 17'h10000;
        dcnt <= '0;
      end else begin
        tq   <= '0;
        rem  <= diff[32:0];
        dcnt <= 5'd16;
      end
    end else if (cmd.div_step) begin
      if (rem2 >= span[33:0]) begin
        rem <= 33'(rem2 - span[33:0]);
        tq  <= {tq[15:0], 1'b1};
      end else begin
        rem <= rem2[32:0];
        tq  <= {tq[15:0], 1'b0};
      end
      dcnt <= dcnt - 5'd1;
    end
  end

  // differences and multiplier operands
  assign dx = 33'(e1.px) - 33'(e0.px);
  assign dy = 33'(e1.py) - 33'(e0.py);
  assign dz = 33'(e1.pz) - 33'(e0.pz);
  assign ds = 17'(e1.speed) - 17'(e0.speed);
  assign df = e1.facing - e0.facing;
  assign bigc[0] = (dx > 33'sd65535) || (dx < -33'sd65535);
  assign bigc[1] = (dy > 33'sd65535) || (dy < -33'sd65535);
  assign bigc[2] = (dz > 33'sd65535) || (dz < -33'sd65535);

  always_comb begin
    ma = '0;
    mb = '0;
    dsel = dx;
    unique case (mcnt)
      4'd0, 4'd3: dsel = dx;
      4'd1, 4'd4: dsel = dy;
      4'd2, 4'd5: dsel = dz;
      default:    dsel = dx;
    endcase
    priority if (mcnt < 4'd3) begin
      ma = bigc[mcnt[1:0]] ? '0 : 34'(dsel);
      mb = dsel[17:0];
    end else if (mcnt < 4'd6) begin
      ma = 34'(dsel);
      mb = $signed({1'b0, tq});
    end else if (mcnt == 4'd6) begin
      ma = 34'(ds);
      mb = $signed({1'b0, tq});
    end else if (mcnt == 4'd7) begin
      ma = 34'(df);
      mb = $signed({1'b0, tq});
    end else begin
      ma = '0;
      mb = '0;
    end
  end

  assign kd  = mcnt - 4'd1;
  assign rnd = 36'((prod + 52'sd32768) >>> 16);
  assign ftr = (prod < 0) ? (prod + 52'sd65535) : prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      mcnt <= '0;
    end else if (cmd.mul_init) begin
      mcnt <= '0;
      sum  <= '0;
      big  <= |bigc;
    end else if (cmd.mul_step) begin
      prod <= ma * mb;
      if (mcnt != 4'd0) begin
        unique case (kd)
          4'd0, 4'd1, 4'd2: sum <= sum + 35'(prod);
          4'd3: lp_x <= e0.px + 32'(rnd);
          4'd4: lp_y <= e0.py + 32'(rnd);
          4'd5: lp_z <= e0.pz + 32'(rnd);
          4'd6: lp_s <= e0.speed + 16'(rnd);
          4'd7: lp_f <= e0.facing + 16'(ftr >>> 16);
          default: ;
        endcase
      end
      if (mcnt != 4'd8) mcnt <= mcnt + 4'd1;
    end
  end

  assign snap_now = big || (sum > {3'b000, teleport_dist_sq});

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      have_data       <= 1'b0;
      sample_accepted <= 1'b0;
      snapped         <= 1'b0;
      out_pos_x       <= '0;
      out_pos_y       <= '0;
      out_pos_z       <= '0;
      out_facing      <= '0;
      out_speed       <= '0;
      out_move_state  <= '0;
      out_item_kind   <= '0;
      unique case (cmd.res)
        RES_STORE: sample_accepted <= accepted;
        RES_QUERY: begin
          have_data      <= 1'b1;
          snapped        <= snap_now;
          out_pos_x      <= snap_now ? e1.px : lp_x;
          out_pos_y      <= snap_now ? e1.py : lp_y;
          out_pos_z      <= snap_now ? e1.pz : lp_z;
          out_facing     <= lp_f;
          out_speed      <= lp_s;
          out_move_state <= e1.move;
          out_item_kind  <= e1.item;
        end
        default: ;
      endcase
    end
  end

endmodule
